FILE: rtl/adc_pkg.sv
// Shared types, codes and helpers for the address distance classifier.
// No dependencies; imported by the classifier top level.
`default_nettype none

package adc_pkg;

   localparam int ADDR_W = 64;

   typedef enum logic {
      FUNC_LOAD     = 1'b0,
      FUNC_CLASSIFY = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      DIST_LOOPBACK = 2'd0,
      DIST_DIRECT   = 2'd1,
      DIST_ROUTED   = 2'd2
   } dist_type;

   localparam logic [7:0]  V6_LL_BYTE0   = 8'hfe;
   localparam logic [7:0]  V6_LL_B1_MASK = 8'hc0;
   localparam logic [7:0]  V6_LL_B1_VAL  = 8'h80;
   localparam logic [15:0] V4_LL_PREFIX  = 16'ha9fe;

   typedef struct packed {
      logic              ipv6;
      logic [ADDR_W-1:0] addr_high;
      logic [ADDR_W-1:0] addr_low;
      logic [ADDR_W-1:0] mask_high;
      logic [ADDR_W-1:0] mask_low;
   } entry_type;

   typedef struct packed {
      logic exact;
      logic prefix;
   } match_type;

   function automatic logic is_link_local(input logic v6, input logic [ADDR_W-1:0] hi,
                                          input logic [ADDR_W-1:0] lo);
      logic result;
      if (v6) begin
         result = (hi[63:56] == V6_LL_BYTE0) &&
                  ((hi[55:48] & V6_LL_B1_MASK) == V6_LL_B1_VAL);
      end else begin
         result = (lo[31:16] == V4_LL_PREFIX);
      end
      return result;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/adc_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies; holds the classifier's interface table.
`default_nettype none

module adc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/address_distance_classifier_top.sv
// Address distance classifier: interface table in RAM, sequential table walk per classify word.
// Depends on adc_pkg and adc_ram.
//
//   channel | direction | handshake           | payload
//   req_    | in        | req_valid/req_ready | func, entry_index, entry_valid, is_ipv6,
//           |           |                     | addr_high/low, mask_high/low
//   rsp_    | out       | rsp_valid/rsp_ready | distance, link_local
//
// A load word is written into the table RAM at acceptance.
// A classify word reads one table entry per cycle through the single RAM read port;
// its result is registered from ST_DONE after the ST_SCAN and ST_DRAIN states, and input ready returns with it.
// Reset clears the per-entry valid flip-flops at once; no clearing pass is needed.
// A finished result waits in the output register; a new word is accepted meanwhile,
// and only a later classify result stalls until the waiting one is taken.
`default_nettype none

module address_distance_classifier_top #(
   parameter int NUM_INTERFACES = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_func,
   input  wire logic [2:0]  req_entry_index,
   input  wire logic        req_entry_valid,
   input  wire logic        req_is_ipv6,
   input  wire logic [63:0] req_addr_high,
   input  wire logic [63:0] req_addr_low,
   input  wire logic [63:0] req_mask_high,
   input  wire logic [63:0] req_mask_low,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [1:0]  rsp_distance,
   output logic             rsp_link_local
);

   import adc_pkg::*;

   localparam int IDX_W = (NUM_INTERFACES > 1) ? $clog2(NUM_INTERFACES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_INTERFACES - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;
   logic              rd_vld_ff, rd_vld_in;
   logic              ent_vld_ff, ent_vld_in;
   logic              loop_ff, loop_in;
   logic              direct_ff, direct_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_distance_ff, rsp_distance_in;
   logic              rsp_link_local_ff, rsp_link_local_in;
   logic              tbl_vld_ff [NUM_INTERFACES];

   logic              q_v6_ff;
   logic [ADDR_W-1:0] q_high_ff;
   logic [ADDR_W-1:0] q_low_ff;
   logic              q_ll_ff;

   logic              accept;
   logic              load_acc;
   logic              cls_acc;
   logic              in_range;
   logic [IDX_W-1:0]  wr_idx;
   logic              rd_en;
   logic              rsp_load;
   entry_type         wr_entry;
   entry_type         rd_entry;
   match_type         match;
   logic [ADDR_W-1:0] dh, dl, mh, ml;

   assign accept   = req_valid && req_ready;
   assign load_acc = accept && (req_func == FUNC_LOAD);
   assign cls_acc  = accept && (req_func == FUNC_CLASSIFY);
   assign in_range = (32'(req_entry_index) < NUM_INTERFACES);
   assign wr_idx   = IDX_W'(req_entry_index);
   assign rd_en    = (state_ff == ST_SCAN);
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   assign wr_entry.ipv6      = req_is_ipv6;
   assign wr_entry.addr_high = req_addr_high;
   assign wr_entry.addr_low  = req_addr_low;
   assign wr_entry.mask_high = req_mask_high;
   assign wr_entry.mask_low  = req_mask_low;

   adc_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (NUM_INTERFACES)
   ) u_table (
      .clock   (clock),
      .wr_en   (load_acc && in_range),
      .wr_addr (wr_idx),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff),
      .rd_data (rd_entry)
   );

   always_comb begin
      dh = q_high_ff ^ rd_entry.addr_high;
      dl = q_low_ff ^ rd_entry.addr_low;
      mh = rd_entry.mask_high;
      ml = rd_entry.mask_low;
      if (!q_v6_ff) begin
         dh = '0;
         mh = '0;
         dl = {32'd0, dl[31:0]};
         ml = {32'd0, ml[31:0]};
      end
      match.exact  = (dh == '0) && (dl == '0);
      match.prefix = ((dh & mh) == '0) && ((dl & ml) == '0);
   end

   always_comb begin
      state_in          = state_ff;
      cnt_in            = cnt_ff;
      rd_vld_in         = rd_en;
      ent_vld_in        = rd_en && tbl_vld_ff[cnt_ff];
      loop_in           = loop_ff;
      direct_in         = direct_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_distance_in   = rsp_distance_ff;
      rsp_link_local_in = rsp_link_local_ff;

      if (rd_vld_ff && ent_vld_ff && (rd_entry.ipv6 == q_v6_ff)) begin
         loop_in   = loop_ff || match.exact;
         direct_in = direct_ff || match.prefix;
      end

      case (state_ff)
         ST_IDLE: begin
            if (cls_acc) begin
               state_in  = ST_SCAN;
               cnt_in    = '0;
               loop_in   = 1'b0;
               direct_in = 1'b0;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in      = 1'b1;
               rsp_link_local_in = q_ll_ff;
               if (loop_ff) begin
                  rsp_distance_in = DIST_LOOPBACK;
               end else if (direct_ff) begin
                  rsp_distance_in = DIST_DIRECT;
               end else begin
                  rsp_distance_in = DIST_ROUTED;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         ent_vld_ff   <= 1'b0;
         loop_ff      <= 1'b0;
         direct_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= rd_vld_in;
         ent_vld_ff   <= ent_vld_in;
         loop_ff      <= loop_in;
         direct_ff    <= direct_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_distance_ff   <= rsp_distance_in;
      rsp_link_local_ff <= rsp_link_local_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_INTERFACES; i++) begin
            tbl_vld_ff[i] <= 1'b0;
         end
      end else if (load_acc && in_range) begin
         tbl_vld_ff[wr_idx] <= req_entry_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (cls_acc) begin
         q_v6_ff   <= req_is_ipv6;
         q_high_ff <= req_addr_high;
         q_low_ff  <= req_addr_low;
         q_ll_ff   <= is_link_local(req_is_ipv6, req_addr_high, req_addr_low);
      end
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_distance   = rsp_distance_ff;
   assign rsp_link_local = rsp_link_local_ff;

   a_read_in_walk: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == ST_DRAIN || state_ff == ST_SCAN))
      else $error("table read data outside the table walk");

   a_flags_cleared: assert property (@(posedge clock) disable iff (reset)
      cls_acc |=> (!loop_ff && !direct_ff && state_ff == ST_SCAN && cnt_ff == '0))
      else $error("classify did not start a clean walk");

   a_load_stays_idle: assert property (@(posedge clock) disable iff (reset)
      load_acc |=> (state_ff == ST_IDLE))
      else $error("load word started a table walk");

   a_result_issued: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished walk did not present a result");

   a_loop_wins: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && loop_ff) |=> (rsp_distance_ff == DIST_LOOPBACK))
      else $error("own address not reported as loopback");

endmodule

`default_nettype wire
